// ===== rtl/assert_macros.svh =====
// assertion macros shared by the encoder unit and mce_ctrl
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge, masked while reset is high
`define MCE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same check with no reset masking
`define MCE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mce_pkg.sv =====
// types, constants and morse table for the morse character encoder
// no dependencies
package mce_pkg;

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned DOT_W   = 20;
  localparam int unsigned SEG_W   = 22;
  localparam int unsigned PAT_W   = 5;
  localparam int unsigned CNT_W   = 3;

  localparam logic [DOT_W-1:0] DOT_RESET_VAL = 20'd100000;

  localparam logic [CODE_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CODE_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CODE_W-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CODE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CODE_W-1:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [CODE_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CODE_W-1:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [CODE_W-1:0] CASE_OFFSET  = 8'h20;

  localparam logic [CNT_W-1:0] DIGIT_LEN = 3'd5;

  // element patterns, bit 0 sent first, 1 = dash
  localparam logic [PAT_W-1:0] LETTER_BITS [26] = '{
    5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, 5'b00100, 5'b00011,
    5'b00000, 5'b00000, 5'b01110, 5'b00101, 5'b00010, 5'b00011, 5'b00001,
    5'b00111, 5'b00110, 5'b01011, 5'b00010, 5'b00000, 5'b00001, 5'b00100,
    5'b01000, 5'b00110, 5'b01001, 5'b01101, 5'b00011
  };

  localparam logic [CNT_W-1:0] LETTER_LEN [26] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  localparam logic [PAT_W-1:0] DIGIT_BITS [10] = '{
    5'b11111, 5'b11110, 5'b11100, 5'b11000, 5'b10000,
    5'b00000, 5'b00001, 5'b00011, 5'b00111, 5'b01111
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TONE,
    ST_GAP,
    ST_SPACE,
    ST_CLOSE
  } mce_state_t;

  typedef enum logic [1:0] {
    MULT_1,
    MULT_2,
    MULT_3,
    MULT_4
  } mce_mult_t;

  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [PAT_W-1:0] bits;
    logic             space;
  } mce_pat_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      shift;
    logic      emit;
    logic      tone;
    mce_mult_t mult;
    logic      last;
  } mce_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_pat;
    logic is_space;
    logic last_elem;
    logic cur_dash;
  } mce_stat_t;

  function automatic mce_pat_t morse_lookup(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] u;
    logic [4:0]        li;
    logic [3:0]        di;
    mce_pat_t          p;
    u = c;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      u = c - CASE_OFFSET;
    end
    li = 5'(u - CHAR_UPPER_A);
    di = 4'(u - CHAR_ZERO);
    p.len   = '0;
    p.bits  = '0;
    p.space = 1'b0;
    if (u >= CHAR_UPPER_A && u <= CHAR_UPPER_Z) begin
      p.len  = LETTER_LEN[li];
      p.bits = LETTER_BITS[li];
    end else if (u >= CHAR_ZERO && u <= CHAR_NINE) begin
      p.len  = DIGIT_LEN;
      p.bits = DIGIT_BITS[di];
    end else if (u == CHAR_SPACE) begin
      p.space = 1'b1;
    end
    return p;
  endfunction

endpackage

// ===== rtl/morse_character_encoder_unit.sv =====
// morse character encoder: one character in, one to eleven segments out, one each cycle
// the first segment follows the start request through the state register and the output
// registers; busy is high while the element sequencer runs, and a request is taken only in idle
// synchronous active-high reset: idle, dot time 100000, no strobe; results cannot be held
// depends on mce_pkg, mce_ctrl, mce_dp and assert_macros.svh
module morse_character_encoder_unit (
  input  logic                            clk,
  input  logic                            rst,
  // character request
  input  logic                            start,
  output logic                            busy,
  input  logic [mce_pkg::CODE_W-1:0]      char_code,
  // dot time register
  input  logic                            cfg_we,
  input  logic [mce_pkg::DOT_W-1:0]       cfg_dot_duration,
  // segment results
  output logic                            seg_valid,
  output logic                            tone_on,
  output logic [mce_pkg::SEG_W-1:0]       seg_length,
  output logic                            last_segment
);
  import mce_pkg::*;
  `include "assert_macros.svh"

  // command and status between sequencer and datapath
  mce_cmd_t  cmd;
  mce_stat_t stat;

  // sequencer: tone/gap pairs per element or a word space (nothing for other codes), then the closing gap
  mce_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath: table lookup at request, pattern shift, segment length from dot time
  mce_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_dot_duration (cfg_dot_duration),
    .char_code        (char_code),
    .cmd              (cmd),
    .stat             (stat),
    .seg_valid        (seg_valid),
    .tone_on          (tone_on),
    .seg_length       (seg_length),
    .last_segment     (last_segment)
  );

  // closing gap only ever shows with a strobe
  `MCE_ASSERT(a_last_has_strobe, clk, rst, last_segment |-> seg_valid, "last flag without strobe")
  // once the closing gap is out the unit is free again
  `MCE_ASSERT(a_last_frees_unit, clk, rst, (seg_valid && last_segment) |-> !busy, "busy after closing gap")
  // an accepted request always starts the sequencer
  `MCE_ASSERT(a_accept_sets_busy, clk, rst, (start && !busy) |=> busy, "request accepted without busy")
  // every tone is followed at once by a silence
  `MCE_ASSERT(a_tone_then_silence, clk, rst, (seg_valid && tone_on) |=> (seg_valid && !tone_on), "tone not followed by silence")

endmodule

// ===== rtl/mce_ctrl.sv =====
// sequencing state machine for the morse character encoder
// depends on mce_pkg and assert_macros.svh
module mce_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mce_pkg::mce_stat_t  stat,
  output mce_pkg::mce_cmd_t   cmd
);
  import mce_pkg::*;
  `include "assert_macros.svh"

  mce_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (stat.has_pat) begin
            state_next = ST_TONE;
          end else if (stat.is_space) begin
            state_next = ST_SPACE;
          end else begin
            state_next = ST_CLOSE;
          end
        end
      end
      ST_TONE:  state_next = ST_GAP;
      ST_GAP:   state_next = stat.last_elem ? ST_CLOSE : ST_TONE;
      ST_SPACE: state_next = ST_CLOSE;
      ST_CLOSE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load  = 1'b0;
    cmd.shift = 1'b0;
    cmd.emit  = 1'b0;
    cmd.tone  = 1'b0;
    cmd.mult  = MULT_1;
    cmd.last  = 1'b0;
    busy      = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_TONE: begin
        cmd.emit = 1'b1;
        cmd.tone = 1'b1;
        cmd.mult = stat.cur_dash ? MULT_3 : MULT_1;
      end
      ST_GAP: begin
        cmd.emit  = 1'b1;
        cmd.shift = 1'b1;
      end
      ST_SPACE: begin
        cmd.emit = 1'b1;
        cmd.mult = MULT_4;
      end
      ST_CLOSE: begin
        cmd.emit = 1'b1;
        cmd.mult = MULT_2;
        cmd.last = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  `MCE_ASSERT(a_close_to_idle, clk, rst, (state == ST_CLOSE) |=> (state == ST_IDLE), "close gap not followed by idle")
  `MCE_ASSERT(a_tone_then_gap, clk, rst, (state == ST_TONE) |=> (state == ST_GAP), "tone not followed by gap")
  `MCE_ASSERT(a_shift_with_gap, clk, rst, cmd.shift |-> (cmd.emit && !cmd.tone), "pattern shift outside a gap")

endmodule

// ===== rtl/mce_dp.sv =====
// datapath: dot time register, element pattern store and segment output registers
// depends on mce_pkg
module mce_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mce_pkg::DOT_W-1:0]       cfg_dot_duration,
  input  logic [mce_pkg::CODE_W-1:0]      char_code,
  input  mce_pkg::mce_cmd_t               cmd,
  output mce_pkg::mce_stat_t              stat,
  output logic                            seg_valid,
  output logic                            tone_on,
  output logic [mce_pkg::SEG_W-1:0]       seg_length,
  output logic                            last_segment
);
  import mce_pkg::*;

  logic [DOT_W-1:0] dot_time;
  logic [PAT_W-1:0] pat_bits;
  logic [CNT_W-1:0] pat_cnt;
  mce_pat_t         lookup;
  logic [SEG_W-1:0] dot_ext;
  logic [SEG_W-1:0] len_next;

  assign lookup  = morse_lookup(char_code);
  assign dot_ext = SEG_W'(dot_time);

  assign stat.has_pat   = (lookup.len != '0);
  assign stat.is_space  = lookup.space;
  assign stat.last_elem = (pat_cnt == CNT_W'(1));
  assign stat.cur_dash  = pat_bits[0];

  always_comb begin
    unique case (cmd.mult)
      MULT_1:  len_next = dot_ext;
      MULT_2:  len_next = dot_ext << 1;
      MULT_3:  len_next = dot_ext + (dot_ext << 1);
      MULT_4:  len_next = dot_ext << 2;
      default: len_next = dot_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_time  <= DOT_RESET_VAL;
      seg_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        dot_time <= cfg_dot_duration;
      end
      seg_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pat_bits <= lookup.bits;
      pat_cnt  <= lookup.len;
    end else if (cmd.shift) begin
      pat_bits <= pat_bits >> 1;
      pat_cnt  <= pat_cnt - CNT_W'(1);
    end
    tone_on      <= cmd.tone;
    seg_length   <= len_next;
    last_segment <= cmd.last;
  end

endmodule
